FILE: src/nrt_pkg.sv
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared types and constants of the name registry table: request codes,
// result field widths and the search token that travels along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package nrt_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int INDEX_W  = 7;
    localparam int BOUND_W  = 9;
    localparam int WORD_W   = 64;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd1;

    localparam logic [INDEX_W-1:0] INDEX_NONE = '1;
    localparam logic [BOUND_W-1:0] BOUND_NONE = '1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // search token handed from cell to cell, one hop per cycle
    typedef struct packed {
        logic               active;
        logic               hit;
        logic               appended;
        logic [INDEX_W-1:0] index;
        logic [ID_W-1:0]    id;
    } tok_t;

endpackage

`default_nettype wire

FILE: src/name_registry_table.sv
// ----------------------------------------------------------------------------
// name_registry_table
// Binds names of up to NAME_BYTES bytes to 8-bit task ids in a row of
// ENTRIES slots.
// ----------------------------------------------------------------------------
// One request is handled at a time: a start register launches the search
// token, the token walks the slot row one slot per cycle and its result is
// captured in a result register, which then moves to the output register
// before the next request can be taken. The result sits in an output
// register, so a new request is taken while the previous result still waits;
// a finished search stalls only while that register is still occupied.
// Register binds or rebinds a name (failure with -1 and -1 when the name is
// new and every slot is used); look up returns the slot and id, or -1 and -1
// when the name is absent, with success status; any other mode fails with
// -1 and -1. Name bytes past NAME_BYTES are ignored.
`default_nettype none

module name_registry_table #(
    parameter int ENTRIES    = 64,
    parameter int NAME_BYTES = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [nrt_pkg::MODE_W-1:0]        mode,
    input  wire logic [nrt_pkg::WORD_W-1:0]        name_word0,
    input  wire logic [nrt_pkg::WORD_W-1:0]        name_word1,
    input  wire logic [nrt_pkg::WORD_W-1:0]        name_word2,
    input  wire logic [nrt_pkg::WORD_W-1:0]        name_word3,
    input  wire logic [nrt_pkg::ID_W-1:0]          requester_id,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   status,
    output logic signed [nrt_pkg::INDEX_W-1:0]     entry_index,
    output logic signed [nrt_pkg::BOUND_W-1:0]     bound_id
);

    localparam int KEY_W   = NAME_BYTES * 8;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int NAME_W  = 4 * nrt_pkg::WORD_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_HOLD   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        start_reg;
    logic [KEY_W-1:0]            key_reg;
    logic [nrt_pkg::ID_W-1:0]    qid_reg;
    logic [nrt_pkg::MODE_W-1:0]  mode_reg;

    logic                           res_status_reg;
    logic [nrt_pkg::INDEX_W-1:0]    res_index_reg;
    logic [nrt_pkg::BOUND_W-1:0]    res_bound_reg;
    logic                           res_status_next;
    logic [nrt_pkg::INDEX_W-1:0]    res_index_next;
    logic [nrt_pkg::BOUND_W-1:0]    res_bound_next;

    logic                           out_valid_reg;
    logic                           out_status_reg;
    logic [nrt_pkg::INDEX_W-1:0]    out_index_reg;
    logic [nrt_pkg::BOUND_W-1:0]    out_bound_reg;

    logic [NAME_W-1:0] name_full;
    logic              in_fire;
    logic              out_free;
    logic              query_reg_mode;
    logic              query_lookup;
    nrt_pkg::tok_t     head_tok;
    nrt_pkg::tok_t     tail_tok;

    assign name_full      = {name_word3, name_word2, name_word1, name_word0};
    assign in_ready       = (state_reg == ST_IDLE);
    assign in_fire        = in_valid && in_ready;
    assign out_free       = !out_valid_reg || out_ready;
    assign query_reg_mode = (mode_reg == nrt_pkg::MODE_REGISTER);
    assign query_lookup   = (mode_reg == nrt_pkg::MODE_LOOKUP);

    always_comb
    begin
        head_tok        = '0;
        head_tok.active = start_reg;
    end

    nrt_chain #(
        .ENTRIES (ENTRIES),
        .CNT_W   (CNT_W),
        .KEY_W   (KEY_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_count (count_reg),
        .query_key  (key_reg),
        .query_id   (qid_reg),
        .query_reg  (query_reg_mode),
        .head_tok   (head_tok),
        .tail_tok   (tail_tok)
    );

    // result decode once the token leaves the far end of the row
    always_comb
    begin
        res_status_next = nrt_pkg::STATUS_FAIL;
        res_index_next  = nrt_pkg::INDEX_NONE;
        res_bound_next  = nrt_pkg::BOUND_NONE;
        priority if (!query_reg_mode && !query_lookup)
        begin
            res_status_next = nrt_pkg::STATUS_FAIL;
        end
        else if (tail_tok.hit)
        begin
            res_status_next = nrt_pkg::STATUS_OK;
            res_index_next  = tail_tok.index;
            res_bound_next  = {1'b0, tail_tok.id};
        end
        else if (query_lookup)
        begin
            res_status_next = nrt_pkg::STATUS_OK;
        end
        else
        begin
            // register with no free slot
            res_status_next = nrt_pkg::STATUS_FAIL;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if ((state_reg == ST_SEARCH) && tail_tok.active && tail_tok.appended
            && query_reg_mode)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tail_tok.active)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= in_fire;
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg  <= name_full[KEY_W-1:0];
            qid_reg  <= requester_id;
            mode_reg <= mode;
        end
        if ((state_reg == ST_SEARCH) && tail_tok.active)
        begin
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
            res_bound_reg  <= res_bound_next;
        end
        if ((state_reg == ST_HOLD) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_bound_reg  <= res_bound_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_index = out_index_reg;
    assign bound_id    = out_bound_reg;

    // slot count stays within the row
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("slot count past table size");

    // slot count only ever grows by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("slot count jumped");

    // a token reaches the far end only while a search is running
    a_tail_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.active |-> (state_reg == ST_SEARCH))
        else $error("stray search token");

    // a failed request never names a slot
    a_fail_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == nrt_pkg::STATUS_FAIL))
            |-> ((out_index_reg == nrt_pkg::INDEX_NONE)
                 && (out_bound_reg == nrt_pkg::BOUND_NONE)))
        else $error("failure result with a slot");

endmodule

`default_nettype wire

FILE: src/nrt_cell.sv
// ----------------------------------------------------------------------------
// nrt_cell
// One table slot: holds a name key and its bound id, compares the broadcast
// query as the search token passes, and rebinds or appends in place.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int KEY_W = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [CNT_W-1:0]         used_count,
    input  wire logic [KEY_W-1:0]         query_key,
    input  wire logic [nrt_pkg::ID_W-1:0] query_id,
    input  wire logic                     query_reg,
    input  wire nrt_pkg::tok_t            tok_in,
    output nrt_pkg::tok_t                 tok_out
);

    localparam logic [CNT_W-1:0]            SLOT     = CNT_W'(IDX);
    localparam logic [nrt_pkg::INDEX_W-1:0] SLOT_IDX = nrt_pkg::INDEX_W'(IDX);

    logic [KEY_W-1:0]         key_reg;
    logic [nrt_pkg::ID_W-1:0] id_reg;
    nrt_pkg::tok_t            tok_reg;
    nrt_pkg::tok_t            tok_next;

    logic searching;
    logic occupied;
    logic match;
    logic append;

    assign searching = tok_in.active && !tok_in.hit;
    assign occupied  = SLOT < used_count;
    assign match     = searching && occupied && (key_reg == query_key);
    // first free slot takes a name that no earlier slot held
    assign append    = searching && query_reg && (SLOT == used_count);

    always_comb
    begin
        tok_next = tok_in;
        if (match || append)
        begin
            tok_next.hit      = 1'b1;
            tok_next.appended = append;
            tok_next.index    = SLOT_IDX;
            tok_next.id       = (query_reg) ? query_id : id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_reg && (match || append))
        begin
            id_reg <= query_id;
        end
        if (append)
        begin
            key_reg <= query_key;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: src/nrt_chain.sv
// ----------------------------------------------------------------------------
// nrt_chain
// Row of table slots; the search token enters at slot zero and leaves the
// far end after passing through the token register of every slot.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_chain #(
    parameter int ENTRIES = 64,
    parameter int CNT_W   = 7,
    parameter int KEY_W   = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [CNT_W-1:0]         used_count,
    input  wire logic [KEY_W-1:0]         query_key,
    input  wire logic [nrt_pkg::ID_W-1:0] query_id,
    input  wire logic                     query_reg,
    input  wire nrt_pkg::tok_t            head_tok,
    output nrt_pkg::tok_t                 tail_tok
);

    nrt_pkg::tok_t link [ENTRIES+1];

    assign link[0] = head_tok;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_slot
        nrt_cell #(
            .IDX   (i),
            .CNT_W (CNT_W),
            .KEY_W (KEY_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .used_count (used_count),
            .query_key  (query_key),
            .query_id   (query_id),
            .query_reg  (query_reg),
            .tok_in     (link[i]),
            .tok_out    (link[i+1])
        );
    end

    assign tail_tok = link[ENTRIES];

endmodule

`default_nettype wire
